FILE: src/block_buffer_cache_lru_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the buffer cache tag manager
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_TOP_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBC_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bbc assertion failed");

// Next-cycle implication, checked outside reset.
`define BBC_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bbc assertion failed");

`endif

FILE: src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// Buffer cache package
// Shared constants, codes and structures of the buffer cache tag manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

    localparam int NUM_BUFFERS_DEF = 128;
    localparam int IDX_W           = 10;
    localparam int CNT_W           = 11;
    localparam int DEV_W           = 8;
    localparam int BLK_W           = 32;

    localparam logic [1:0] OP_GET     = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_MARK    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FREE  = 2'd1;
    localparam logic [1:0] ST_RELEASED = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_TAKE,
        CMD_RETAG,
        CMD_RELEASE,
        CMD_MARK
    } cmd_kind_t;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [IDX_W-1:0] idx;
    } req_t;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             hit_loaded;
        logic             hit_free;
        logic [IDX_W-1:0] hit_rank;
        logic             head_ok;
        logic [IDX_W-1:0] head_idx;
        logic             sel_free;
        logic             sel_loaded;
    } wave_t;

    typedef struct packed {
        logic             valid;
        cmd_kind_t        kind;
        logic [IDX_W-1:0] idx;
        logic             remove;
        logic [IDX_W-1:0] rank;
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/bbc_cell.sv
// ----------------------------------------------------------------------------
// Buffer cell
// Holds the tag, loaded mark and free list rank of one buffer, folds its
// state into the passing lookup wave and applies broadcast updates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bbc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire bbc_pkg::req_t  req,
    input  wire bbc_pkg::cmd_t  cmd,
    input  wire bbc_pkg::wave_t wave_in,
    output bbc_pkg::wave_t      wave_out
);

    localparam logic [bbc_pkg::IDX_W-1:0] MY_IDX = bbc_pkg::IDX_W'(CELL_INDEX);

    logic [bbc_pkg::DEV_W-1:0] dev_reg;
    logic [bbc_pkg::BLK_W-1:0] blk_reg;
    logic                      valid_reg;
    logic                      loaded_reg;
    logic                      free_reg;
    logic [bbc_pkg::IDX_W-1:0] rank_reg;
    bbc_pkg::wave_t            wave_reg;
    bbc_pkg::wave_t            wave_next;

    always_comb
    begin
        wave_next = wave_in;
        if (valid_reg && dev_reg == req.dev && blk_reg == req.blk)
        begin
            wave_next.hit        = 1'b1;
            wave_next.hit_idx    = MY_IDX;
            wave_next.hit_loaded = loaded_reg;
            wave_next.hit_free   = free_reg;
            wave_next.hit_rank   = rank_reg;
        end
        if (free_reg && rank_reg == '0)
        begin
            wave_next.head_ok  = 1'b1;
            wave_next.head_idx = MY_IDX;
        end
        if (req.idx == MY_IDX)
        begin
            wave_next.sel_free   = free_reg;
            wave_next.sel_loaded = loaded_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            loaded_reg <= 1'b0;
            free_reg   <= 1'b1;
            rank_reg   <= MY_IDX;
            wave_reg   <= '0;
        end
        else
        begin
            wave_reg <= wave_next;
            if (cmd.valid)
            begin
                if (cmd.remove && free_reg && rank_reg > cmd.rank)
                begin
                    rank_reg <= rank_reg - 1'b1;
                end
                if (cmd.idx == MY_IDX)
                begin
                    unique case (cmd.kind)
                        bbc_pkg::CMD_TAKE:
                        begin
                            free_reg <= 1'b0;
                        end
                        bbc_pkg::CMD_RETAG:
                        begin
                            free_reg   <= 1'b0;
                            valid_reg  <= 1'b1;
                            loaded_reg <= 1'b0;
                        end
                        bbc_pkg::CMD_RELEASE:
                        begin
                            free_reg <= 1'b1;
                            rank_reg <= cmd.rank;
                        end
                        bbc_pkg::CMD_MARK:
                        begin
                            loaded_reg <= 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.idx == MY_IDX && cmd.kind == bbc_pkg::CMD_RETAG)
        begin
            dev_reg <= cmd.dev;
            blk_reg <= cmd.blk;
        end
    end

    assign wave_out = wave_reg;

endmodule

`default_nettype wire

FILE: src/block_buffer_cache_lru_top.sv
// Requests are taken one at a time: a new request is accepted only after the
// previous one's lookup wave has passed the row of buffer cells, one cell per
// cycle, and its result has been loaded into the output register.
// Reset: every buffer untagged, not loaded and free, in index order.
// Reset takes effect at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// Buffer cache tag manager
// Get, release and mark-loaded requests over a pool of buffers with an
// LRU free list, built as a row of buffer cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "block_buffer_cache_lru_top_macros.svh"

module block_buffer_cache_lru_top #(
    parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // Bits from low: dev_number[7:0], block_number[39:8], buffer_index[46:40].
    input  wire logic [47:0] s_tdata,
    // Bits from low: operation[1:0].
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // Bits from low: result_buffer[6:0], hit[7], needs_read[8], status[10:9].
    output logic [15:0]      m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [1:0]                op_reg;
    bbc_pkg::req_t             req_reg;
    bbc_pkg::wave_t            wave_start_reg;
    bbc_pkg::wave_t            wave [NUM_BUFFERS+1];
    bbc_pkg::cmd_t             cmd_reg;
    bbc_pkg::cmd_t             cmd_next;
    logic [bbc_pkg::CNT_W-1:0] free_count_reg;
    logic [bbc_pkg::CNT_W-1:0] free_count_next;
    logic [10:0]               res_reg;
    logic [10:0]               res_next;
    logic                      m_tvalid_reg;
    logic [10:0]               m_data_reg;
    logic                      in_range;
    bbc_pkg::wave_t            w;

    assign w        = wave[NUM_BUFFERS];
    assign in_range = (32'(req_reg.idx) < NUM_BUFFERS);
    assign wave[0]  = wave_start_reg;

    for (genvar i = 0; i < NUM_BUFFERS; i++)
    begin : g_cell
        bbc_cell #(
            .CELL_INDEX(i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .req     (req_reg),
            .cmd     (cmd_reg),
            .wave_in (wave[i]),
            .wave_out(wave[i+1])
        );
    end

    always_comb
    begin
        logic [6:0] rbuf;
        logic       hit;
        logic       nread;
        logic [1:0] status;
        rbuf            = '0;
        hit             = 1'b0;
        nread           = 1'b0;
        status          = bbc_pkg::ST_OK;
        cmd_next        = '0;
        cmd_next.kind   = bbc_pkg::CMD_NONE;
        cmd_next.dev    = req_reg.dev;
        cmd_next.blk    = req_reg.blk;
        cmd_next.idx    = req_reg.idx;
        free_count_next = free_count_reg;
        unique case (op_reg)
            bbc_pkg::OP_GET:
            begin
                if (w.hit)
                begin
                    rbuf  = w.hit_idx[6:0];
                    hit   = 1'b1;
                    nread = !w.hit_loaded;
                    if (w.hit_free)
                    begin
                        cmd_next.valid  = 1'b1;
                        cmd_next.kind   = bbc_pkg::CMD_TAKE;
                        cmd_next.idx    = w.hit_idx;
                        cmd_next.remove = 1'b1;
                        cmd_next.rank   = w.hit_rank;
                        free_count_next = free_count_reg - 1'b1;
                    end
                end
                else if (free_count_reg == '0 || !w.head_ok)
                begin
                    status = bbc_pkg::ST_NO_FREE;
                end
                else
                begin
                    rbuf            = w.head_idx[6:0];
                    nread           = 1'b1;
                    cmd_next.valid  = 1'b1;
                    cmd_next.kind   = bbc_pkg::CMD_RETAG;
                    cmd_next.idx    = w.head_idx;
                    cmd_next.remove = 1'b1;
                    cmd_next.rank   = '0;
                    free_count_next = free_count_reg - 1'b1;
                end
            end
            bbc_pkg::OP_RELEASE:
            begin
                rbuf = req_reg.idx[6:0];
                if (in_range)
                begin
                    nread = !w.sel_loaded;
                    if (w.sel_free)
                    begin
                        status = bbc_pkg::ST_RELEASED;
                    end
                    else
                    begin
                        cmd_next.valid  = 1'b1;
                        cmd_next.kind   = bbc_pkg::CMD_RELEASE;
                        cmd_next.rank   = free_count_reg[bbc_pkg::IDX_W-1:0];
                        free_count_next = free_count_reg + 1'b1;
                    end
                end
            end
            bbc_pkg::OP_MARK:
            begin
                rbuf = req_reg.idx[6:0];
                if (in_range)
                begin
                    cmd_next.valid = 1'b1;
                    cmd_next.kind  = bbc_pkg::CMD_MARK;
                end
            end
            default:
            begin
            end
        endcase
        res_next = {status, nread, hit, rbuf};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            wave_start_reg <= '0;
            cmd_reg        <= '0;
            free_count_reg <= bbc_pkg::CNT_W'(NUM_BUFFERS);
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            wave_start_reg <= '0;
            cmd_reg        <= '0;
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        wave_start_reg.valid <= 1'b1;
                        state_reg            <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (w.valid)
                    begin
                        cmd_reg        <= cmd_next;
                        free_count_reg <= free_count_next;
                        state_reg      <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            op_reg      <= s_tuser;
            req_reg.dev <= s_tdata[7:0];
            req_reg.blk <= s_tdata[39:8];
            req_reg.idx <= bbc_pkg::IDX_W'(s_tdata[46:40]);
        end
        if (state_reg == S_SCAN && w.valid)
        begin
            res_reg <= res_next;
        end
        if (state_reg == S_DONE && (!m_tvalid_reg || m_tready))
        begin
            m_data_reg <= res_reg;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_data_reg};

    `BBC_ASSERT_IMP(a_free_count_bound, 1'b1, 32'(free_count_reg) <= NUM_BUFFERS)
    `BBC_ASSERT_IMP(a_wave_in_scan, w.valid, state_reg == S_SCAN)
    `BBC_ASSERT_IMP(a_cmd_in_done, cmd_reg.valid, state_reg == S_DONE)
    `BBC_ASSERT_NXT(a_done_from_scan, state_reg == S_SCAN && w.valid, state_reg == S_DONE)

endmodule

`default_nettype wire

FILE: tb/block_buffer_cache_lru_top_tb.sv
// ----------------------------------------------------------------------------
// Buffer cache tag manager testbench
// Drives get, release and mark-loaded requests with random bursts and
// output stalls, and checks each result against a tag, chain and LRU
// free list model kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_cache_lru_top_tb;

    localparam int NBUF = 128;
    localparam int NBKT = 32;
    localparam int NIL  = -1;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [6:0]  idx;
    } request_t;

    typedef struct packed {
        logic [6:0] buf_idx;
        logic       hit;
        logic       needs_read;
        logic [1:0] status;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    block_buffer_cache_lru_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    logic [7:0]  tag_dev_q   [NBUF];
    logic [31:0] tag_blk_q   [NBUF];
    bit          tagged_q    [NBUF];
    bit          loaded_q    [NBUF];
    bit          is_free_q   [NBUF];
    int          fnext       [NBUF];
    int          fprev       [NBUF];
    int          cnext       [NBUF];
    int          cprev       [NBUF];
    int          bucket_top  [NBKT];
    int          lru_head;
    int          lru_tail;

    request_t    pending_reqs [$];
    answer_t     expected_answers [$];
    int          mismatches;
    int          burst_left;
    int          gap_left;
    int          stall_phase;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        mismatches++;
    endtask

    function automatic int bucket_of(input logic [7:0] d, input logic [31:0] b);
        return int'(({24'd0, d} ^ b) % NBKT);
    endfunction

    function automatic void lru_unlink(input int b);
        int n;
        int p;
        if (!is_free_q[b])
            return;
        n = fnext[b];
        p = fprev[b];
        if (n != NIL) fprev[n] = p; else lru_tail = p;
        if (p != NIL) fnext[p] = n; else lru_head = n;
        fnext[b] = NIL;
        fprev[b] = NIL;
        is_free_q[b] = 0;
    endfunction

    function automatic void cache_reset();
        for (int i = 0; i < NBUF; i++)
        begin
            tag_dev_q[i] = '0;
            tag_blk_q[i] = '0;
            tagged_q[i] = 0;
            loaded_q[i] = 0;
            is_free_q[i] = 1;
            fnext[i] = (i + 1 < NBUF) ? i + 1 : NIL;
            fprev[i] = (i > 0) ? i - 1 : NIL;
            cnext[i] = NIL;
            cprev[i] = NIL;
        end
        for (int i = 0; i < NBKT; i++)
            bucket_top[i] = NIL;
        lru_head = 0;
        lru_tail = NBUF - 1;
    endfunction

    function automatic answer_t cache_lookup(input request_t r);
        answer_t a;
        int h;
        int b;
        int found;
        int v;
        int oh;
        a = '0;
        if (r.op == bbc_pkg::OP_GET)
        begin
            h = bucket_of(r.dev, r.blk);
            b = bucket_top[h];
            found = NIL;
            while (b != NIL)
            begin
                if (tagged_q[b] && tag_dev_q[b] == r.dev && tag_blk_q[b] == r.blk)
                begin
                    found = b;
                    break;
                end
                b = cnext[b];
            end
            if (found != NIL)
            begin
                lru_unlink(found);
                a.buf_idx = found[6:0];
                a.hit = 1'b1;
                a.needs_read = !loaded_q[found];
            end
            else if (lru_head == NIL)
                a.status = bbc_pkg::ST_NO_FREE;
            else
            begin
                v = lru_head;
                lru_unlink(v);
                if (tagged_q[v])
                begin
                    oh = bucket_of(tag_dev_q[v], tag_blk_q[v]);
                    if (cnext[v] != NIL) cprev[cnext[v]] = cprev[v];
                    if (cprev[v] != NIL) cnext[cprev[v]] = cnext[v];
                    if (bucket_top[oh] == v) bucket_top[oh] = cnext[v];
                end
                tag_dev_q[v] = r.dev;
                tag_blk_q[v] = r.blk;
                tagged_q[v] = 1;
                loaded_q[v] = 0;
                cnext[v] = bucket_top[h];
                cprev[v] = NIL;
                if (bucket_top[h] != NIL) cprev[bucket_top[h]] = v;
                bucket_top[h] = v;
                a.buf_idx = v[6:0];
                a.needs_read = 1'b1;
            end
        end
        else if (r.op == bbc_pkg::OP_RELEASE || r.op == bbc_pkg::OP_MARK)
        begin
            b = int'(r.idx);
            a.buf_idx = r.idx;
            if (r.op == bbc_pkg::OP_RELEASE)
            begin
                if (is_free_q[b])
                    a.status = bbc_pkg::ST_RELEASED;
                else
                begin
                    fnext[b] = NIL;
                    fprev[b] = lru_tail;
                    if (lru_tail != NIL) fnext[lru_tail] = b; else lru_head = b;
                    lru_tail = b;
                    is_free_q[b] = 1;
                end
            end
            else
                loaded_q[b] = 1;
            a.needs_read = !loaded_q[b];
        end
        return a;
    endfunction

    function automatic void add_req(input logic [1:0] op, input logic [7:0] d,
                                    input logic [31:0] b, input logic [6:0] i);
        request_t r;
        r.op = op;
        r.dev = d;
        r.blk = b;
        r.idx = i;
        pending_reqs.push_back(r);
    endfunction

    // Driver: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            automatic bit busy = s_tvalid && !s_tready;
            automatic int bl = burst_left;
            automatic int gl = gap_left;
            if (s_tvalid && s_tready)
                bl = bl - 1;
            if (!busy)
            begin
                if (bl <= 0 && gl <= 0)
                begin
                    bl = $urandom_range(1, 8);
                    gl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
                end
                if (gl > 0 && bl <= 0)
                    gl = gl - 1;
                if (bl > 0 && pending_reqs.size() > 0)
                begin
                    automatic request_t r = pending_reqs.pop_front();
                    expected_answers.push_back(cache_lookup(r));
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, r.idx, r.blk, r.dev};
                    s_tuser <= r.op;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (bl > 0 && pending_reqs.size() == 0)
                        bl = 0;
                end
            end
            burst_left <= bl;
            gap_left <= gl;
        end
    end

    // Receiver stalls in a pattern of its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[11])
                m_tready <= 1'b1;
            else if (stall_phase[9])
                m_tready <= ($urandom_range(0, 9) != 0);
            else
                m_tready <= ($urandom_range(0, 1) == 0) ? 1'b1 : ($urandom_range(0, 200) == 0);
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_answers.size() == 0)
                report("unexpected result", m_tdata, 16'h0);
            else
            begin
                automatic answer_t e = expected_answers.pop_front();
                if (m_tdata[6:0] !== e.buf_idx)
                    report("result_buffer", {9'd0, m_tdata[6:0]}, {9'd0, e.buf_idx});
                if (m_tdata[7] !== e.hit)
                    report("hit", {15'd0, m_tdata[7]}, {15'd0, e.hit});
                if (m_tdata[8] !== e.needs_read)
                    report("needs_read", {15'd0, m_tdata[8]}, {15'd0, e.needs_read});
                if (m_tdata[10:9] !== e.status)
                    report("status", {14'd0, m_tdata[10:9]}, {14'd0, e.status});
            end
        end
    end

    initial
    begin
        int kind;
        logic [7:0] d;
        logic [31:0] b;
        mismatches = 0;
        cache_reset();
        rst_n = 1'b0;

        add_req(bbc_pkg::OP_GET, 8'h00, 32'h0000_0000, 7'd0);
        add_req(bbc_pkg::OP_GET, 8'h00, 32'h0000_0000, 7'd0);
        add_req(bbc_pkg::OP_GET, 8'hFF, 32'hFFFF_FFFF, 7'h7F);
        add_req(bbc_pkg::OP_GET, 8'h1F, 32'h0000_0000, 7'd0);
        add_req(bbc_pkg::OP_GET, 8'h00, 32'h0000_001F, 7'd0);
        add_req(bbc_pkg::OP_MARK, 8'h00, 32'h0, 7'd0);
        add_req(bbc_pkg::OP_GET, 8'h00, 32'h0000_0000, 7'd0);
        add_req(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 7'd0);
        add_req(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 7'd0);
        add_req(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 7'h7F);
        add_req(bbc_pkg::OP_MARK, 8'h00, 32'h0, 7'h7F);
        add_req(2'd3, 8'hAA, 32'h5555_AAAA, 7'h55);
        add_req(bbc_pkg::OP_GET, 8'h00, 32'h0000_0000, 7'd0);
        add_req(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 7'd2);
        add_req(bbc_pkg::OP_GET, 8'h12, 32'h0000_0040, 7'd0);
        for (int i = 0; i < 130; i++)
            add_req(bbc_pkg::OP_GET, 8'h5A, 32'(i), 7'd0);
        add_req(bbc_pkg::OP_GET, 8'hC3, 32'hDEAD_BEEF, 7'd0);
        for (int i = 0; i < 128; i++)
            add_req(bbc_pkg::OP_RELEASE, 8'h00, 32'h0, 7'(i));

        for (int i = 0; i < 900; i++)
        begin
            kind = $urandom_range(0, 99);
            d = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            b = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 150));
            if (kind < 50)
                add_req(bbc_pkg::OP_GET, d, b, 7'($urandom));
            else if (kind < 80)
                add_req(bbc_pkg::OP_RELEASE, 8'($urandom), $urandom, 7'($urandom));
            else if (kind < 97)
                add_req(bbc_pkg::OP_MARK, 8'($urandom), $urandom, 7'($urandom));
            else
                add_req(2'd3, 8'($urandom), $urandom, 7'($urandom));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0);
        @(posedge clk);
        wait (!s_tvalid || s_tready);
        @(posedge clk);
        wait (expected_answers.size() == 0);
        repeat (2 * NBUF + 10) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
